[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. The assertion bodies are compiled only
// in simulation; synthesis sees empty macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define BLAC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition must never be true outside reset
`define BLAC_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define BLAC_ASSERT(lbl, clk, rst, prop)
`define BLAC_NEVER(lbl, clk, rst, cond)

`endif

`endif

[hdl/blac_pkg.sv]
// ----------------------------------------------------------------------------
// blac_pkg
// Shared widths, parameter defaults and the update control bundle of the
// clustering comparison accumulator.
// ----------------------------------------------------------------------------
package blac_pkg;

  // Fixed field widths
  localparam int LABEL_W = 4;
  localparam int SUM_W   = 26;
  localparam int OBS_W   = 13;

  // Parameter defaults
  localparam int DEF_MAX_CLUSTERS = 16;
  localparam int DEF_MAX_OBS      = 4096;

  // Per-cycle update control for the count stores
  typedef struct packed {
    logic inc;    // add one at the addressed entry
    logic clear;  // zero every entry (wins over inc)
  } blac_upd_t;

endpackage

[hdl/blac_ram.sv]
// ----------------------------------------------------------------------------
// blac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module blac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/blac_label_counts.sv]
// ----------------------------------------------------------------------------
// blac_label_counts
// Per-label observation counters of one clustering: one read and one
// increment per cycle at the same label; clear zeroes every counter at once.
// ----------------------------------------------------------------------------
module blac_label_counts import blac_pkg::*; #(
  parameter int NUM_LABELS = DEF_MAX_CLUSTERS,
  parameter int CNT_W      = $clog2(DEF_MAX_OBS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [$clog2(NUM_LABELS)-1:0] lbl,
  input  blac_upd_t                     upd,
  output logic [CNT_W-1:0]              count
);

  logic [CNT_W-1:0] cnt [NUM_LABELS];

  assign count = cnt[lbl];

  // Increment the addressed counter; clear wipes all
  always_ff @(posedge clk) begin
    if (rst || upd.clear) begin
      for (int i = 0; i < NUM_LABELS; i++) begin
        cnt[i] <= '0;
      end
    end else if (upd.inc) begin
      cnt[lbl] <= count + 1'b1;
    end
  end

endmodule

[hdl/blac_pair_table.sv]
// ----------------------------------------------------------------------------
// blac_pair_table
// Contingency table of pair counts. Counts live in a RAM read at item accept,
// ahead of the work stage; per-entry valid bits give instant clearing, and
// a one-entry bypass covers a write landing after the next item's read.
// ----------------------------------------------------------------------------
module blac_pair_table import blac_pkg::*; #(
  parameter int DEPTH = DEF_MAX_CLUSTERS * DEF_MAX_CLUSTERS,
  parameter int CNT_W = $clog2(DEF_MAX_OBS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  // read side, at item accept
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_idx,
  // update side, for the item in the work stage
  input  logic [$clog2(DEPTH)-1:0] idx,
  input  blac_upd_t                upd,
  output logic [CNT_W-1:0]         count
);

  logic [DEPTH-1:0] vld;
  logic [CNT_W-1:0] ram_q;
  logic [CNT_W-1:0] count_next;
  logic             fwd_hit;
  logic [CNT_W-1:0] fwd_data;

  blac_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (upd.inc),
    .waddr (idx),
    .wdata (count_next),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (ram_q)
  );

  // Current count: bypass first, then RAM if the entry was written since clear
  always_comb begin
    if (fwd_hit) begin
      count = fwd_data;
    end else if (vld[idx]) begin
      count = ram_q;
    end else begin
      count = '0;
    end
  end

  assign count_next = count + 1'b1;

  // Bypass: the read for the incoming item misses a same-cycle write
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= upd.inc && !upd.clear && (rd_idx == idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= count_next;
    end
  end

  // Entry valid bits
  always_ff @(posedge clk) begin
    if (rst || upd.clear) begin
      vld <= '0;
    end else if (upd.inc) begin
      vld[idx] <= 1'b1;
    end
  end

endmodule

[hdl/binder_loss_accumulator.sv]
// ----------------------------------------------------------------------------
// binder_loss_accumulator
// Compares two clusterings of the same observations and returns the exact
// numerator sum(r^2) + sum(c^2) - 2*sum(p^2) with the observation count.
// ----------------------------------------------------------------------------
// Usage: send one item per observation with both cluster labels; labels at
// or above the cluster limit count as the top cluster. The item flagged
// is_last yields one result (numerator, n, overflow), after which all
// counts restart from zero at once, with no clearing pass. The block takes
// one item every clock cycle, pausing only while a result waits under stall
// and the next last item sits in the input register. A result is registered
// as its last item leaves the input register; the pair-count RAM is read
// when an item is accepted and written back as the item leaves that
// register, together with the result register, with a one-entry bypass for
// back-to-back hits. Items beyond MAX_OBS only raise overflow.
// Divide the numerator by n*n in software for the scaled loss.
`include "assert_macros.svh"

module binder_loss_accumulator import blac_pkg::*; #(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int MAX_OBS      = DEF_MAX_OBS
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [LABEL_W-1:0] label_first,
  input  logic [LABEL_W-1:0] label_second,
  input  logic               is_last,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SUM_W-1:0]   disagreement_sum,
  output logic [OBS_W-1:0]   observation_total,
  output logic               overflow
);

  // Only labels reachable through the input field need storage
  localparam int NUM_LABELS = (MAX_CLUSTERS < (1 << LABEL_W)) ? MAX_CLUSTERS
                                                              : (1 << LABEL_W);
  localparam int LBL_W      = $clog2(NUM_LABELS);
  localparam int PAIR_DEPTH = NUM_LABELS * NUM_LABELS;
  localparam int PAIR_W     = $clog2(PAIR_DEPTH);
  localparam int CNT_W      = $clog2(MAX_OBS + 1);

  logic              accept;
  logic              fire;
  logic [LBL_W-1:0]  in_a;
  logic [LBL_W-1:0]  in_b;
  logic [PAIR_W-1:0] in_idx;

  // work stage
  logic              s1_valid;
  logic [LBL_W-1:0]  s1_a;
  logic [LBL_W-1:0]  s1_b;
  logic [PAIR_W-1:0] s1_idx;
  logic              s1_last;

  // running state
  logic [SUM_W-1:0]  running_sum;
  logic [CNT_W-1:0]  seen;
  logic              ovf;

  logic              room;
  blac_upd_t         upd;
  logic [CNT_W-1:0]  r_cnt;
  logic [CNT_W-1:0]  c_cnt;
  logic [CNT_W-1:0]  p_cnt;
  logic [SUM_W+CNT_W-1:0] r_ext;
  logic [SUM_W+CNT_W-1:0] c_ext;
  logic [SUM_W+CNT_W-1:0] p_ext;
  logic [SUM_W-1:0]  delta;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  seen_next;
  logic              ovf_next;
  logic [OBS_W+CNT_W-1:0] seen_ext;

  // Handshake: work stage moves on unless its result cannot be parked
  assign fire     = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;
  assign accept   = in_valid && !in_stall;

  // Label saturation and pair index
  always_comb begin
    if (label_first >= LABEL_W'(NUM_LABELS - 1)) begin
      in_a = LBL_W'(NUM_LABELS - 1);
    end else begin
      in_a = label_first[LBL_W-1:0];
    end
    if (label_second >= LABEL_W'(NUM_LABELS - 1)) begin
      in_b = LBL_W'(NUM_LABELS - 1);
    end else begin
      in_b = label_second[LBL_W-1:0];
    end
    in_idx = PAIR_W'(PAIR_W'(in_a) * PAIR_W'(NUM_LABELS)) + PAIR_W'(in_b);
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_a    <= in_a;
      s1_b    <= in_b;
      s1_idx  <= in_idx;
      s1_last <= is_last;
    end
  end

  // Count stores
  assign room = (seen < CNT_W'(MAX_OBS));
  assign upd  = '{inc: fire && room, clear: fire && s1_last};

  blac_label_counts #(
    .NUM_LABELS (NUM_LABELS),
    .CNT_W      (CNT_W)
  ) u_first (
    .clk   (clk),
    .rst   (rst),
    .lbl   (s1_a),
    .upd   (upd),
    .count (r_cnt)
  );

  blac_label_counts #(
    .NUM_LABELS (NUM_LABELS),
    .CNT_W      (CNT_W)
  ) u_second (
    .clk   (clk),
    .rst   (rst),
    .lbl   (s1_b),
    .upd   (upd),
    .count (c_cnt)
  );

  blac_pair_table #(
    .DEPTH (PAIR_DEPTH),
    .CNT_W (CNT_W)
  ) u_pairs (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_idx (in_idx),
    .idx    (s1_idx),
    .upd    (upd),
    .count  (p_cnt)
  );

  // Square increments: 2r+1 + 2c+1 - 2(2p+1) = 2(r + c - 2p), modulo field
  assign r_ext = {{SUM_W{1'b0}}, r_cnt};
  assign c_ext = {{SUM_W{1'b0}}, c_cnt};
  assign p_ext = {{SUM_W{1'b0}}, p_cnt};
  assign delta = r_ext[SUM_W-1:0] + c_ext[SUM_W-1:0]
               - {p_ext[SUM_W-2:0], 1'b0};

  always_comb begin
    if (room) begin
      sum_next  = running_sum + {delta[SUM_W-2:0], 1'b0};
      seen_next = seen + 1'b1;
    end else begin
      sum_next  = running_sum;
      seen_next = seen;
    end
    ovf_next = ovf || !room;
  end

  // Running totals, restarted after a last item
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      seen        <= '0;
      ovf         <= 1'b0;
    end else if (fire) begin
      if (s1_last) begin
        running_sum <= '0;
        seen        <= '0;
        ovf         <= 1'b0;
      end else begin
        running_sum <= sum_next;
        seen        <= seen_next;
        ovf         <= ovf_next;
      end
    end
  end

  // Result register
  assign seen_ext = {{OBS_W{1'b0}}, seen_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_last) begin
      disagreement_sum  <= sum_next;
      observation_total <= seen_ext[OBS_W-1:0];
      overflow          <= ovf_next;
    end
  end

  // Checks
  `BLAC_ASSERT(a_result_from_last, clk, rst, $rose(out_valid) |-> $past(fire && s1_last))
  `BLAC_ASSERT(a_stall_cause, clk, rst, in_stall |-> (s1_valid && s1_last && out_valid))
  `BLAC_NEVER(a_seen_bound, clk, rst, seen > CNT_W'(MAX_OBS))
  `BLAC_ASSERT(a_ovf_at_limit, clk, rst, ovf |-> (seen == CNT_W'(MAX_OBS)))

endmodule
